>>> sv/two_button_gesture_decoder_core_defines.svh
// Assertion macros for the two-button gesture decoder.
// Used by files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef TWO_BUTTON_GESTURE_DECODER_CORE_DEFINES_SVH
`define TWO_BUTTON_GESTURE_DECODER_CORE_DEFINES_SVH

// Check a property on every rising edge outside reset
`define TBGD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that a condition never holds outside reset
`define TBGD_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

>>> sv/tbgd_pkg.sv
// Shared types and constants of the two-button gesture decoder.
// No dependencies; imported by the channel interfaces and all modules.
package tbgd_pkg;

    // Tick counter width, 16 to 32
    localparam int TIME_BITS = 32;

    localparam int DEB_W      = 10;
    localparam int WIN_W      = 14;
    localparam int HOLD_W     = 14;
    localparam int RAMP_W     = 10;
    localparam int BRIGHT_W   = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    typedef logic [TIME_BITS-1:0] tick_t;

    // Register reset values
    localparam logic [DEB_W-1:0]    DEBOUNCE_RST = 10'd25;
    localparam logic [WIN_W-1:0]    WINDOW_RST   = 14'd400;
    localparam logic [HOLD_W-1:0]   LONG_A_RST   = 14'd1000;
    localparam logic [HOLD_W-1:0]   LONG_B_RST   = 14'd800;
    localparam logic [RAMP_W-1:0]   RAMP_RST     = 10'd75;
    localparam logic [BRIGHT_W-1:0] BMAX_RST     = 7'd100;
    localparam logic [BRIGHT_W-1:0] BMIN_RST     = 7'd20;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE = 3'd0,
        CFG_WINDOW   = 3'd1,
        CFG_LONG_A   = 3'd2,
        CFG_LONG_B   = 3'd3,
        CFG_RAMP     = 3'd4,
        CFG_BMAX     = 3'd5,
        CFG_BMIN     = 3'd6
    } cfg_index_t;

    // Debounced level and accepted edges of one button for the current tick
    typedef struct packed {
        logic stable;
        logic fell;
        logic rose;
    } btn_edge_t;

    // One result item
    typedef struct packed {
        logic                single_click;
        logic                double_click;
        logic                ramp_start;
        logic                ramp_going_up;
        logic                ramp_end;
        logic                bright_write;
        logic [BRIGHT_W-1:0] bright_next;
        logic                power_off;
        logic                battery_show;
    } result_t;

endpackage

>>> sv/tbgd_in_if.sv
// Tick sample channel: valid/ready handshake with raw button levels and brightness.
// Depends on tbgd_pkg for field widths.
interface tbgd_in_if
    import tbgd_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                level_a;
    logic                level_b;
    logic [BRIGHT_W-1:0] bright_now;

    modport source (output valid, level_a, level_b, bright_now, input ready);
    modport sink   (input valid, level_a, level_b, bright_now, output ready);
endinterface

>>> sv/tbgd_out_if.sv
// Result channel: valid/ready handshake with the gesture event bits.
// Depends on tbgd_pkg for field widths.
interface tbgd_out_if
    import tbgd_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                single_click;
    logic                double_click;
    logic                ramp_start;
    logic                ramp_going_up;
    logic                ramp_end;
    logic                bright_write;
    logic [BRIGHT_W-1:0] bright_next;
    logic                power_off;
    logic                battery_show;

    modport source (output valid, single_click, double_click, ramp_start, ramp_going_up,
                    ramp_end, bright_write, bright_next, power_off, battery_show,
                    input ready);
    modport sink   (input valid, single_click, double_click, ramp_start, ramp_going_up,
                    ramp_end, bright_write, bright_next, power_off, battery_show,
                    output ready);
endinterface

>>> sv/two_button_gesture_decoder_core.sv
// Two-button gesture decoder: click, double click, long press ramp and power keys.
// Depends on tbgd_pkg, tbgd_in_if, tbgd_out_if, tbgd_debounce and the defines header.
//
// Usage:
//   samples : one item per millisecond tick (raw active-low levels of both
//             buttons and the present brightness).
//   results : exactly one item per sample, carrying the event bits and the
//             brightness to apply when bright_write is set.
//   cfg_*   : write port for the seven timing and limit registers; write only
//             while no result is outstanding.
// A result is presented in the cycle after its sample is taken.
// Throughput: one sample per cycle without stalls. All decoding is one combinational
// pass from the held button state to the result register, and the result register
// lets a new sample in during the cycle in which the previous result leaves.
// When the receiver stalls, the pending result holds and samples.ready drops
// until it is taken; no tick is lost.
// Reset: tick counter and button state clear, both buttons read as released,
// ramp direction is up, and the registers take their default values.
`include "two_button_gesture_decoder_core_defines.svh"

module two_button_gesture_decoder_core
    import tbgd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    tbgd_in_if.sink               samples,
    tbgd_out_if.source            results,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers
    logic [DEB_W-1:0]    debounce_reg;
    logic [WIN_W-1:0]    window_reg;
    logic [HOLD_W-1:0]   long_a_reg;
    logic [HOLD_W-1:0]   long_b_reg;
    logic [RAMP_W-1:0]   ramp_int_reg;
    logic [BRIGHT_W-1:0] bmax_reg;
    logic [BRIGHT_W-1:0] bmin_reg;

    // Gesture state
    tick_t tick_reg;
    tick_t a_press_reg;
    tick_t b_press_reg;
    tick_t step_time_reg;
    tick_t deadline_reg;
    logic  a_long_reg;
    logic  b_long_reg;
    logic  dir_up_reg;
    logic  ramp_on_reg;
    logic  pending_reg;

    tick_t a_press_next;
    tick_t b_press_next;
    tick_t step_time_next;
    tick_t deadline_next;
    logic  a_long_next;
    logic  b_long_next;
    logic  dir_up_next;
    logic  ramp_on_next;
    logic  pending_next;

    // Result register
    logic    out_valid_reg;
    result_t result_reg;
    result_t result_next;

    logic      step;
    btn_edge_t a_edge;
    btn_edge_t b_edge;
    tick_t     now;
    tick_t     d_old;
    tick_t     d_new;
    logic      long_a_hit;
    logic      long_b_hit;
    logic      ramp_due;

    assign now             = tick_reg;
    assign samples.ready   = !out_valid_reg || results.ready;
    assign step            = samples.valid && samples.ready;

    tbgd_debounce u_deb_a
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .raw         (samples.level_a),
        .now         (now),
        .debounce_ms (debounce_reg),
        .status      (a_edge)
    );

    tbgd_debounce u_deb_b
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .raw         (samples.level_b),
        .now         (now),
        .debounce_ms (debounce_reg),
        .status      (b_edge)
    );

    // Decode one tick, in the order the gestures take precedence
    always_comb
    begin
        result_next             = '0;
        result_next.bright_next = samples.bright_now;

        // Button one press starts a fresh hold
        a_press_next = a_edge.fell ? now : a_press_reg;
        a_long_next  = a_edge.fell ? 1'b0 : a_long_reg;
        pending_next = pending_reg;
        dir_up_next  = dir_up_reg;
        ramp_on_next = ramp_on_reg;
        step_time_next = step_time_reg;
        deadline_next  = deadline_reg;

        // Long press on button one: flip direction and start the ramp
        long_a_hit = !a_edge.stable && !a_long_next
                     && ((now - a_press_next) >= TIME_BITS'(long_a_reg));
        if (long_a_hit)
        begin
            a_long_next            = 1'b1;
            pending_next           = 1'b0;
            dir_up_next            = !dir_up_reg;
            ramp_on_next           = 1'b1;
            step_time_next         = now;
            result_next.ramp_start = 1'b1;
        end

        // Release of button one: end the ramp, or count a click
        d_old = now - deadline_reg;
        if (a_edge.rose)
        begin
            if (a_long_next)
            begin
                ramp_on_next         = 1'b0;
                result_next.ramp_end = 1'b1;
                a_long_next          = 1'b0;
            end
            else if (pending_next && ((d_old == '0) || d_old[TIME_BITS-1]))
            begin
                result_next.double_click = 1'b1;
                pending_next             = 1'b0;
            end
            else
            begin
                pending_next  = 1'b1;
                deadline_next = now + TIME_BITS'(window_reg);
            end
        end

        // Step the ramp once per interval, clamped to the limits
        ramp_due = ramp_on_next && ((now - step_time_next) >= TIME_BITS'(ramp_int_reg));
        if (ramp_due)
        begin
            step_time_next = now;
            if (dir_up_next)
            begin
                if (samples.bright_now < bmax_reg)
                begin
                    result_next.bright_next  = samples.bright_now + 7'd1;
                    result_next.bright_write = 1'b1;
                end
            end
            else if (samples.bright_now > bmin_reg)
            begin
                result_next.bright_next  = samples.bright_now - 7'd1;
                result_next.bright_write = 1'b1;
            end
        end

        // Confirm a single click once the window has run out
        d_new = now - deadline_next;
        if (pending_next && !d_new[TIME_BITS-1])
        begin
            result_next.single_click = 1'b1;
            pending_next             = 1'b0;
        end

        // Button two press: power off and cancel the ramp
        b_press_next = b_edge.fell ? now : b_press_reg;
        b_long_next  = b_edge.fell ? 1'b0 : b_long_reg;
        if (b_edge.fell)
        begin
            ramp_on_next          = 1'b0;
            result_next.power_off = 1'b1;
        end

        // Long hold on button two: battery display
        long_b_hit = !b_edge.stable && !b_long_next
                     && ((now - b_press_next) >= TIME_BITS'(long_b_reg));
        if (long_b_hit)
        begin
            b_long_next              = 1'b1;
            result_next.battery_show = 1'b1;
        end

        // Short release of button two: power off again
        if (b_edge.rose)
        begin
            if (!b_long_next)
            begin
                ramp_on_next          = 1'b0;
                result_next.power_off = 1'b1;
            end
            b_long_next = 1'b0;
        end

        result_next.ramp_going_up = dir_up_next;
    end

    // Advance gesture state on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg      <= '0;
            a_press_reg   <= '0;
            b_press_reg   <= '0;
            step_time_reg <= '0;
            deadline_reg  <= '0;
            a_long_reg    <= 1'b0;
            b_long_reg    <= 1'b0;
            dir_up_reg    <= 1'b1;
            ramp_on_reg   <= 1'b0;
            pending_reg   <= 1'b0;
        end
        else if (step)
        begin
            tick_reg      <= now + 1'b1;
            a_press_reg   <= a_press_next;
            b_press_reg   <= b_press_next;
            step_time_reg <= step_time_next;
            deadline_reg  <= deadline_next;
            a_long_reg    <= a_long_next;
            b_long_reg    <= b_long_next;
            dir_up_reg    <= dir_up_next;
            ramp_on_reg   <= ramp_on_next;
            pending_reg   <= pending_next;
        end
    end

    // Write configuration registers; drop writes beyond the register list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RST;
            window_reg   <= WINDOW_RST;
            long_a_reg   <= LONG_A_RST;
            long_b_reg   <= LONG_B_RST;
            ramp_int_reg <= RAMP_RST;
            bmax_reg     <= BMAX_RST;
            bmin_reg     <= BMIN_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_DEBOUNCE: debounce_reg <= cfg_data[DEB_W-1:0];
                CFG_WINDOW:   window_reg   <= cfg_data[WIN_W-1:0];
                CFG_LONG_A:   long_a_reg   <= cfg_data[HOLD_W-1:0];
                CFG_LONG_B:   long_b_reg   <= cfg_data[HOLD_W-1:0];
                CFG_RAMP:     ramp_int_reg <= cfg_data[RAMP_W-1:0];
                CFG_BMAX:     bmax_reg     <= cfg_data[BRIGHT_W-1:0];
                CFG_BMIN:     bmin_reg     <= cfg_data[BRIGHT_W-1:0];
                default:      ;
            endcase
        end
    end

    // Hold the result until taken; refill in the same cycle it leaves
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            result_reg <= result_next;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.single_click  = result_reg.single_click;
    assign results.double_click  = result_reg.double_click;
    assign results.ramp_start    = result_reg.ramp_start;
    assign results.ramp_going_up = result_reg.ramp_going_up;
    assign results.ramp_end      = result_reg.ramp_end;
    assign results.bright_write  = result_reg.bright_write;
    assign results.bright_next   = result_reg.bright_next;
    assign results.power_off     = result_reg.power_off;
    assign results.battery_show  = result_reg.battery_show;

    // A click is either single or double, never both
    `TBGD_ASSERT_NEVER(a_click_excl, out_valid_reg && result_reg.single_click && result_reg.double_click, "single and double click in one item")
    // A ramp cannot begin and end on the same tick
    `TBGD_ASSERT_NEVER(a_ramp_excl, out_valid_reg && result_reg.ramp_start && result_reg.ramp_end, "ramp start and end in one item")
    // Every accepted sample leaves a result waiting
    `TBGD_ASSERT(a_result_follows, step |=> out_valid_reg, "accepted item produced no result")

endmodule

>>> sv/tbgd_debounce.sv
// Stable-time debouncer for one active-low button, advanced once per item.
// Depends on tbgd_pkg for the tick type and the edge struct.
module tbgd_debounce
    import tbgd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic             raw,
    input  tick_t            now,
    input  logic [DEB_W-1:0] debounce_ms,
    output btn_edge_t        status
);

    logic  prev_level_reg;
    logic  stable_reg;
    tick_t change_time_reg;
    tick_t change_time_next;
    tick_t held;
    logic  settle;

    // Restart the hold timer on any raw change, then accept a level held long enough
    always_comb
    begin
        change_time_next = (raw != prev_level_reg) ? now : change_time_reg;
        held             = now - change_time_next;
        settle           = (held >= TIME_BITS'(debounce_ms)) && (raw != stable_reg);
        status.stable    = settle ? raw : stable_reg;
        status.fell      = settle && !raw;
        status.rose      = settle && raw;
    end

    // Hold state between items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_level_reg  <= 1'b1;
            stable_reg      <= 1'b1;
            change_time_reg <= '0;
        end
        else if (step)
        begin
            prev_level_reg  <= raw;
            stable_reg      <= status.stable;
            change_time_reg <= change_time_next;
        end
    end

endmodule

>>> tb/sv/two_button_gesture_decoder_core_tb.sv
// Self-checking testbench for the two-button gesture decoder core.
// Drives tick items with random gaps and stalls, predicts every result item in
// SystemVerilog and compares it field by field. Needs tbgd_pkg and both channel interfaces.
module two_button_gesture_decoder_core_tb
    import tbgd_pkg::*;
();

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SPAN_CAP     = 120;
    localparam int REPORT_LIMIT = 10;
    localparam int IDLE_PCT     = 36;
    localparam int LAST_PHASE   = 7;

    // Debounce and hold-time state of one button
    typedef struct packed {
        logic  stable;
        logic  prev_level;
        tick_t change_t;
        tick_t press_t;
        logic  long_done;
    } key_state_t;

    // One row of the directed stimulus table
    typedef struct {
        logic                la;
        logic                lb;
        logic [BRIGHT_W-1:0] br;
        bit                  fixed;
        result_t             want;
    } tick_row_t;

    logic           clk = 1'b0;
    logic           rst_n;
    logic           cfg_write;
    cfg_index_t     cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tbgd_in_if  tick_ch ();
    tbgd_out_if event_ch ();

    two_button_gesture_decoder_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (tick_ch),
        .results   (event_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // Registers as the decoder holds them
    logic [DEB_W-1:0]    deb_ticks;
    logic [WIN_W-1:0]    click_window;
    logic [HOLD_W-1:0]   hold_a;
    logic [HOLD_W-1:0]   hold_b;
    logic [RAMP_W-1:0]   ramp_gap;
    logic [BRIGHT_W-1:0] br_max;
    logic [BRIGHT_W-1:0] br_min;

    // Gesture state
    tick_t      tick_now;
    key_state_t key_a;
    key_state_t key_b;
    logic       ramp_up;
    logic       ramp_run;
    tick_t      ramp_last;
    logic       click_wait;
    tick_t      click_due;

    result_t    gesture_q[$];
    result_t    last_gesture;
    bit         row_fixed;
    result_t    row_want;
    bit         sender_gaps;
    bit         receiver_stalls;
    int         error_count;
    int         cycle_count;
    result_t    seen;
    result_t    due;
    bit         differs;

    function automatic void clear_gesture_state();
        deb_ticks    = DEBOUNCE_RST;
        click_window = WINDOW_RST;
        hold_a       = LONG_A_RST;
        hold_b       = LONG_B_RST;
        ramp_gap     = RAMP_RST;
        br_max       = BMAX_RST;
        br_min       = BMIN_RST;
        tick_now     = '0;
        key_a        = '{stable: 1'b1, prev_level: 1'b1, change_t: '0, press_t: '0,
                         long_done: 1'b0};
        key_b        = key_a;
        ramp_up      = 1'b1;
        ramp_run     = 1'b0;
        ramp_last    = '0;
        click_wait   = 1'b0;
        click_due    = '0;
    endfunction

    // Accept a raw level once it has held for the debounce time
    function automatic key_state_t debounce_key(input key_state_t k, input logic raw,
                                                input tick_t now, output logic fell,
                                                output logic rose);
        key_state_t n;
        n    = k;
        fell = 1'b0;
        rose = 1'b0;
        if (raw != n.prev_level)
        begin
            n.prev_level = raw;
            n.change_t   = now;
        end
        if (tick_t'(now - n.change_t) >= tick_t'(deb_ticks) && raw != n.stable)
        begin
            n.stable = raw;
            if (!raw)
            begin
                n.press_t   = now;
                n.long_done = 1'b0;
                fell        = 1'b1;
            end
            else
                rose = 1'b1;
        end
        return n;
    endfunction

    function automatic result_t predict_gesture(input logic raw_a, input logic raw_b,
                                                input logic [BRIGHT_W-1:0] br);
        result_t r;
        logic    a_fell, a_rose, b_fell, b_rose;
        tick_t   now;
        tick_t   gap;
        now           = tick_now;
        r             = '0;
        r.bright_next = br;
        key_a = debounce_key(key_a, raw_a, now, a_fell, a_rose);
        key_b = debounce_key(key_b, raw_b, now, b_fell, b_rose);

        // Long hold of button one flips the direction and starts the ramp
        if (!key_a.stable && !key_a.long_done
            && tick_t'(now - key_a.press_t) >= tick_t'(hold_a))
        begin
            key_a.long_done = 1'b1;
            click_wait      = 1'b0;
            ramp_up         = ~ramp_up;
            ramp_run        = 1'b1;
            ramp_last       = now;
            r.ramp_start    = 1'b1;
        end

        // Release of button one: end the ramp, or count a click
        if (a_rose)
        begin
            if (key_a.long_done)
            begin
                ramp_run        = 1'b0;
                r.ramp_end      = 1'b1;
                key_a.long_done = 1'b0;
            end
            else
            begin
                gap = now - click_due;
                if (click_wait && (gap == '0 || gap[TIME_BITS-1]))
                begin
                    r.double_click = 1'b1;
                    click_wait     = 1'b0;
                end
                else
                begin
                    click_wait = 1'b1;
                    click_due  = now + tick_t'(click_window);
                end
            end
        end

        // Step the brightness, held inside the limits
        if (ramp_run && tick_t'(now - ramp_last) >= tick_t'(ramp_gap))
        begin
            ramp_last = now;
            if (ramp_up && br < br_max)
            begin
                r.bright_next  = br + 1'b1;
                r.bright_write = 1'b1;
            end
            else if (!ramp_up && br > br_min)
            begin
                r.bright_next  = br - 1'b1;
                r.bright_write = 1'b1;
            end
        end

        // Window closed with no second click
        gap = now - click_due;
        if (click_wait && !gap[TIME_BITS-1])
        begin
            r.single_click = 1'b1;
            click_wait     = 1'b0;
        end

        // Button two: press, long hold, release
        if (b_fell)
        begin
            ramp_run        = 1'b0;
            r.power_off     = 1'b1;
            key_b.long_done = 1'b0;
            key_b.press_t   = now;
        end
        if (!key_b.stable && !key_b.long_done
            && tick_t'(now - key_b.press_t) >= tick_t'(hold_b))
        begin
            key_b.long_done = 1'b1;
            r.battery_show  = 1'b1;
        end
        if (b_rose)
        begin
            if (!key_b.long_done)
            begin
                ramp_run    = 1'b0;
                r.power_off = 1'b1;
            end
            key_b.long_done = 1'b0;
        end

        r.ramp_going_up = ramp_up;
        tick_now        = now + 1'b1;
        return r;
    endfunction

    function automatic string show_result(input result_t r);
        return $sformatf("sc=%0b dc=%0b rs=%0b up=%0b re=%0b bw=%0b bn=%0d po=%0b bs=%0b",
                         r.single_click, r.double_click, r.ramp_start, r.ramp_going_up,
                         r.ramp_end, r.bright_write, r.bright_next, r.power_off,
                         r.battery_show);
    endfunction

    // Predict on every accepted tick, check every accepted result, bound the run
    always @(posedge clk)
    begin
        if (rst_n && tick_ch.valid && tick_ch.ready)
        begin
            last_gesture = predict_gesture(tick_ch.level_a, tick_ch.level_b,
                                           tick_ch.bright_now);
            gesture_q.push_back(row_fixed ? row_want : last_gesture);
        end
        if (rst_n && event_ch.valid && event_ch.ready)
        begin
            seen = {event_ch.single_click, event_ch.double_click, event_ch.ramp_start,
                    event_ch.ramp_going_up, event_ch.ramp_end, event_ch.bright_write,
                    event_ch.bright_next, event_ch.power_off, event_ch.battery_show};
            if (gesture_q.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("unexpected result item: %s", show_result(seen));
            end
            else
            begin
                due     = gesture_q.pop_front();
                differs = (seen.single_click  !== due.single_click)  ||
                          (seen.double_click  !== due.double_click)  ||
                          (seen.ramp_start    !== due.ramp_start)    ||
                          (seen.ramp_going_up !== due.ramp_going_up) ||
                          (seen.ramp_end      !== due.ramp_end)      ||
                          (seen.bright_write  !== due.bright_write)  ||
                          (seen.bright_next   !== due.bright_next)   ||
                          (seen.power_off     !== due.power_off)     ||
                          (seen.battery_show  !== due.battery_show);
                if (differs)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("mismatch at cycle %0d\n  expected %s\n  actual   %s",
                                 cycle_count, show_result(due), show_result(seen));
                end
            end
        end
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Stall the result side at random
    initial
    begin
        event_ch.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            event_ch.ready <= !(receiver_stalls && $urandom_range(99) < IDLE_PCT);
        end
    end

    // Hand one tick item over, with random gaps before it; return at a falling edge
    task automatic send_tick(input logic la, input logic lb, input logic [BRIGHT_W-1:0] br,
                             input bit fixed, input result_t want);
        while (sender_gaps && $urandom_range(99) < IDLE_PCT)
        begin
            tick_ch.valid <= 1'b0;
            @(negedge clk);
        end
        row_fixed            = fixed;
        row_want             = want;
        tick_ch.valid       <= 1'b1;
        tick_ch.level_a     <= la;
        tick_ch.level_b     <= lb;
        tick_ch.bright_now  <= br;
        do
            @(posedge clk);
        while (!tick_ch.ready);
        @(negedge clk);
    endtask

    // Write one register and mirror it in the predictor
    task automatic write_reg(input cfg_index_t idx, input int unsigned value);
        logic [CFG_DATA_W-1:0] v;
        v          = CFG_DATA_W'(value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(negedge clk);
        case (idx)
            CFG_DEBOUNCE: deb_ticks    = v[DEB_W-1:0];
            CFG_WINDOW:   click_window = v[WIN_W-1:0];
            CFG_LONG_A:   hold_a       = v[HOLD_W-1:0];
            CFG_LONG_B:   hold_b       = v[HOLD_W-1:0];
            CFG_RAMP:     ramp_gap     = v[RAMP_W-1:0];
            CFG_BMAX:     br_max       = v[BRIGHT_W-1:0];
            CFG_BMIN:     br_min       = v[BRIGHT_W-1:0];
            default: ;
        endcase
    endtask

    // Load the register set of one phase and report how many ticks it runs
    task automatic apply_setting(input int phase, output int ticks);
        int unsigned s[7];
        case (phase)
            0: begin s = '{0, 2, 2, 2, 1, 127, 0}; ticks = 0; end
            1: begin s = '{DEBOUNCE_RST, WINDOW_RST, LONG_A_RST, LONG_B_RST, RAMP_RST,
                           BMAX_RST, BMIN_RST}; ticks = 150; end
            2: begin s = '{2, 12, 20, 25, 3, 100, 20}; ticks = 300; end
            3: begin s = '{0, 0, 0, 1, 1, 127, 0}; ticks = 200; end
            4: begin s = '{1, 6, 10, 15, 1, 90, 85}; ticks = 250; end
            5:
            begin
                s = '{$urandom_range(0, 5), $urandom_range(0, 30), $urandom_range(1, 40),
                      $urandom_range(1, 40), $urandom_range(1, 8), $urandom_range(0, 127),
                      $urandom_range(0, 127)};
                ticks = 300;
            end
            // Widest values the write port allows, upper data bits above the register too
            6: begin s = '{16383, 16383, 16383, 0, 16383, 0, 127}; ticks = 100; end
            default: begin s = '{2, 10, 15, 15, 2, 127, 0}; ticks = 150; end
        endcase
        write_reg(CFG_DEBOUNCE, s[0]);
        write_reg(CFG_WINDOW,   s[1]);
        write_reg(CFG_LONG_A,   s[2]);
        write_reg(CFG_LONG_B,   s[3]);
        write_reg(CFG_RAMP,     s[4]);
        write_reg(CFG_BMAX,     s[5]);
        write_reg(CFG_BMIN,     s[6]);
        cfg_write <= 1'b0;
    endtask

    // Length of the next level span of a button, shaped by the current registers
    function automatic int unsigned pick_span(input logic pressed, input int unsigned hold,
                                              input bit rare);
        int unsigned lo, span, w;
        lo = deb_ticks + 1;
        w  = (click_window > 60) ? 60 : click_window;
        if (pressed)
        begin
            if ($urandom_range(99) < 55)
                span = lo + $urandom_range(0, ((hold > 60) ? 60 : hold) / 2);
            else
                span = lo + hold + $urandom_range(0, 4 * ramp_gap + 10);
        end
        else if ($urandom_range(99) < 50)
            span = lo + $urandom_range(0, w);
        else
            span = lo + click_window + $urandom_range(1, 20);
        if (rare && !pressed)
            span += $urandom_range(0, 40);
        if (span > SPAN_CAP)
            span = SPAN_CAP;
        return span;
    endfunction

    initial
    begin
        tick_row_t           plan[$];
        int                  ticks;
        logic                a_tgt, b_tgt, ra, rb;
        int unsigned         a_left, b_left, a_bounce, b_bounce;
        logic [BRIGHT_W-1:0] bright_level;
        logic [BRIGHT_W-1:0] br;
        int unsigned         pick;

        rst_n              <= 1'b0;
        cfg_write          <= 1'b0;
        cfg_index          <= CFG_DEBOUNCE;
        cfg_data           <= '0;
        tick_ch.valid      <= 1'b0;
        tick_ch.level_a    <= 1'b1;
        tick_ch.level_b    <= 1'b1;
        tick_ch.bright_now <= '0;
        row_fixed           = 1'b0;
        row_want            = '0;
        sender_gaps         = 1'b1;
        receiver_stalls     = 1'b1;
        error_count         = 0;
        cycle_count         = 0;
        clear_gesture_state();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: short timings so every gesture fits in a few ticks
        apply_setting(0, ticks);
        // Both released straight after reset: no event, direction up, brightness passed on
        plan.push_back('{1'b1, 1'b1, 7'd127, 1'b1, {6'b000100, 7'd127, 2'b00}});
        plan.push_back('{1'b1, 1'b1, 7'd0,   1'b1, {6'b000100, 7'd0,   2'b00}});
        // single click, then double click inside the window
        plan.push_back('{1'b0, 1'b1, 7'd64, 1'b0, '0});
        plan.push_back('{1'b1, 1'b1, 7'd64, 1'b0, '0});
        plan.push_back('{1'b1, 1'b1, 7'd64, 1'b0, '0});
        plan.push_back('{1'b1, 1'b1, 7'd64, 1'b0, '0});
        plan.push_back('{1'b0, 1'b1, 7'd64, 1'b0, '0});
        plan.push_back('{1'b1, 1'b1, 7'd64, 1'b0, '0});
        plan.push_back('{1'b0, 1'b1, 7'd64, 1'b0, '0});
        plan.push_back('{1'b1, 1'b1, 7'd64, 1'b0, '0});
        // long press ramping down: clamp at the floor, one step, release ends it
        plan.push_back('{1'b0, 1'b1, 7'd0,   1'b0, '0});
        plan.push_back('{1'b0, 1'b1, 7'd0,   1'b0, '0});
        plan.push_back('{1'b0, 1'b1, 7'd0,   1'b0, '0});
        plan.push_back('{1'b0, 1'b1, 7'd0,   1'b0, '0});
        plan.push_back('{1'b0, 1'b1, 7'd127, 1'b0, '0});
        plan.push_back('{1'b1, 1'b1, 7'd127, 1'b0, '0});
        // long press ramping up, clamp at the top, cut short by button two
        plan.push_back('{1'b0, 1'b1, 7'd127, 1'b0, '0});
        plan.push_back('{1'b0, 1'b1, 7'd127, 1'b0, '0});
        plan.push_back('{1'b0, 1'b1, 7'd127, 1'b0, '0});
        plan.push_back('{1'b0, 1'b1, 7'd127, 1'b0, '0});
        plan.push_back('{1'b0, 1'b0, 7'd5,   1'b0, '0});
        plan.push_back('{1'b0, 1'b0, 7'd5,   1'b0, '0});
        plan.push_back('{1'b0, 1'b0, 7'd5,   1'b0, '0});
        plan.push_back('{1'b1, 1'b1, 7'd5,   1'b0, '0});
        // button two short press and release
        plan.push_back('{1'b1, 1'b0, 7'd5,   1'b0, '0});
        plan.push_back('{1'b1, 1'b1, 7'd5,   1'b0, '0});
        foreach (plan[i])
            send_tick(plan[i].la, plan[i].lb, plan[i].br, plan[i].fixed, plan[i].want);

        // Random part: button gestures with bounce, some noise, brightness fed back
        a_tgt        = 1'b1;
        b_tgt        = 1'b1;
        a_left       = 0;
        b_left       = 0;
        a_bounce     = 0;
        b_bounce     = 0;
        bright_level = BRIGHT_W'($urandom_range(0, 127));
        for (int phase = 1; phase <= LAST_PHASE; phase++)
        begin
            // Hold off until every result is back, then reprogram
            tick_ch.valid <= 1'b0;
            while (gesture_q.size() != 0)
                @(negedge clk);
            apply_setting(phase, ticks);
            sender_gaps     = (phase != LAST_PHASE);
            receiver_stalls = (phase != LAST_PHASE);
            for (int n = 0; n < ticks; n++)
            begin
                if (a_left == 0)
                begin
                    a_tgt    = ~a_tgt;
                    a_left   = pick_span(!a_tgt, hold_a, 1'b0);
                    a_bounce = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
                end
                if (b_left == 0)
                begin
                    b_tgt    = ~b_tgt;
                    b_left   = pick_span(!b_tgt, hold_b, 1'b1);
                    b_bounce = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
                end
                ra = a_tgt;
                rb = b_tgt;
                if (a_bounce != 0)
                begin
                    ra = 1'($urandom_range(1));
                    a_bounce--;
                end
                if (b_bounce != 0)
                begin
                    rb = 1'($urandom_range(1));
                    b_bounce--;
                end
                a_left--;
                b_left--;
                if ($urandom_range(99) < 4)
                begin
                    ra = 1'($urandom_range(1));
                    rb = 1'($urandom_range(1));
                end
                pick = $urandom_range(99);
                if (pick < 85)
                    br = bright_level;
                else if (pick < 90)
                    br = '0;
                else if (pick < 95)
                    br = '1;
                else
                    br = BRIGHT_W'($urandom_range(0, 127));
                if ($urandom_range(99) < 2)
                    bright_level = BRIGHT_W'($urandom_range(0, 127));
                send_tick(ra, rb, br, 1'b0, '0);
                if (last_gesture.bright_write)
                    bright_level = last_gesture.bright_next;
            end
        end

        // Drain and let the pipeline settle
        tick_ch.valid <= 1'b0;
        while (gesture_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (error_count == 0 && gesture_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
